// ----- rtl/spnt_pkg.sv -----
// shared types and constants of the spectral peak note tracker
`default_nettype none
package spnt_pkg;

  localparam int FreqW = 56;

  localparam logic [FreqW-1:0] FoldLow  = 56'd1845493760;
  localparam logic [FreqW-1:0] FoldHigh = 56'd44241861775;
  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam logic [6:0] NoteRest = 7'd0;
  localparam logic [6:0] NoteBase = 7'd24;

  localparam logic CfgNoiseFloor = 1'b0;
  localparam logic CfgBinWidth   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_FREQ, ST_LOAD1, ST_FOLD1, ST_OCT1, ST_CNT1,
    ST_LOAD2, ST_FOLD2, ST_OCT2, ST_CNT2, ST_DECIDE
  } state_t;

  typedef struct packed {
    logic mul;
    logic freq;
    logic load;
    logic fold;
    logic oct;
    logic cnt;
    logic save1;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic fold_done;
    logic oct_done;
    logic emit;
    logic out_busy;
  } sts_t;

  function automatic logic [FreqW-1:0] note_edge(input logic [3:0] m);
    logic [FreqW-1:0] e;
    unique case (m)
      4'd0: e = 56'd1899570854;
      4'd1: e = 56'd2012525215;
      4'd2: e = 56'd2132196192;
      4'd3: e = 56'd2258983176;
      4'd4: e = 56'd2393309305;
      4'd5: e = 56'd2535622882;
      4'd6: e = 56'd2686398865;
      4'd7: e = 56'd2846140454;
      4'd8: e = 56'd3015380773;
      4'd9: e = 56'd3194684644;
      4'd10: e = 56'd3384650479;
      default: e = 56'd3585912270;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/spectral_peak_note_tracker.sv -----
// top level of the spectral peak note tracker
// Input channel in_*: one FFT bin per request, in_tdata = {bin_imag, bin_real}
// and in_tlast marks the last bin of a frame. Bins are taken one per cycle while no note search runs.
// The peak search runs on every bin with a combinational squared magnitude.
// At the last bin the frame peak is latched and a note search runs:
// a multiply step and a frequency step, then for each of two frequencies a
// load, a fold loop of one doubling or halving per cycle until the value
// lies between the fold bounds, an octave loop that raises the octave up to 4
// and a 12-entry boundary compare, then a decide step that waits while the
// previous result is still unsent. in_tready is low while the search runs.
// A note change loads one result into the output register on out_* (note and
// frame count), valid from the cycle after the decide cycle. While out_tready
// is low the result waits there and bins keep flowing; only a second finished
// note stalls the search, and so in_tready, until the first one is taken.
// cfg_*: register 0 noise_floor, register 1 bin_width_hz; write only while idle.
// Reset (rst_n low, synchronous) clears the peak, bin position, held note,
// the output register and restores register defaults.
`default_nettype none
module spectral_peak_note_tracker #(
  parameter int FRAME_BINS = 1024,
  parameter int BIN_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [2*BIN_BITS-1:0]   in_tdata,   // bin_real, bin_imag
  input  wire logic                    in_tlast,   // last_bin
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [23:0]                  out_tdata,  // note_number, frames_held, zero pad
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [23:0]             cfg_data
);
  logic [23:0] noise_floor_r;
  logic [15:0] bin_width_r;
  spnt_pkg::cmd_t cmd;
  spnt_pkg::sts_t sts;
  logic busy, bin_take;
  logic [6:0] res_note;
  logic [15:0] res_count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_floor_r <= '0;
      bin_width_r <= 16'd11026;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spnt_pkg::CfgNoiseFloor: noise_floor_r <= cfg_data;
        spnt_pkg::CfgBinWidth:   bin_width_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign bin_take = in_tvalid && in_tready;
  assign out_tdata = {1'b0, res_count, res_note};

  spnt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(bin_take && in_tlast),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  spnt_dp #(.FRAME_BINS(FRAME_BINS), .BIN_BITS(BIN_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .bin_take(bin_take),
    .bin_real(in_tdata[BIN_BITS-1:0]), .bin_imag(in_tdata[2*BIN_BITS-1:BIN_BITS]),
    .last_bin(in_tlast), .noise_floor(noise_floor_r), .bin_width_hz(bin_width_r),
    .cmd(cmd), .out_ready(out_tready), .sts(sts), .res_valid(out_tvalid),
    .res_note(res_note), .res_count(res_count)
  );
endmodule
`default_nettype wire

// ----- rtl/spnt_ctrl.sv -----
// controller sequencing the frame-end note search
`default_nettype none
module spnt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire spnt_pkg::sts_t  sts,
  output spnt_pkg::cmd_t       cmd,
  output logic                 busy
);
  spnt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= spnt_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spnt_pkg::ST_IDLE:  if (start) state_nxt = spnt_pkg::ST_MUL;
      spnt_pkg::ST_MUL:   state_nxt = spnt_pkg::ST_FREQ;
      spnt_pkg::ST_FREQ:  state_nxt = spnt_pkg::ST_LOAD1;
      spnt_pkg::ST_LOAD1: state_nxt = spnt_pkg::ST_FOLD1;
      spnt_pkg::ST_FOLD1: if (sts.fold_done) state_nxt = spnt_pkg::ST_OCT1;
      spnt_pkg::ST_OCT1:  if (sts.oct_done) state_nxt = spnt_pkg::ST_CNT1;
      spnt_pkg::ST_CNT1:  state_nxt = spnt_pkg::ST_LOAD2;
      spnt_pkg::ST_LOAD2: state_nxt = spnt_pkg::ST_FOLD2;
      spnt_pkg::ST_FOLD2: if (sts.fold_done) state_nxt = spnt_pkg::ST_OCT2;
      spnt_pkg::ST_OCT2:  if (sts.oct_done) state_nxt = spnt_pkg::ST_CNT2;
      spnt_pkg::ST_CNT2:  state_nxt = spnt_pkg::ST_DECIDE;
      // a finished note waits here while the previous one is still unsent
      spnt_pkg::ST_DECIDE:
        if (!(sts.emit && sts.out_busy)) state_nxt = spnt_pkg::ST_IDLE;
      default: state_nxt = spnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != spnt_pkg::ST_IDLE);
    unique case (state_r)
      spnt_pkg::ST_MUL:   cmd.mul = 1'b1;
      spnt_pkg::ST_FREQ:  cmd.freq = 1'b1;
      spnt_pkg::ST_LOAD1, spnt_pkg::ST_LOAD2: cmd.load = 1'b1;
      spnt_pkg::ST_FOLD1, spnt_pkg::ST_FOLD2: cmd.fold = 1'b1;
      spnt_pkg::ST_OCT1,  spnt_pkg::ST_OCT2:  cmd.oct = 1'b1;
      spnt_pkg::ST_CNT1: begin
        cmd.cnt = 1'b1;
        cmd.save1 = 1'b1;
      end
      spnt_pkg::ST_CNT2:   cmd.cnt = 1'b1;
      spnt_pkg::ST_DECIDE: cmd.decide = !(sts.emit && sts.out_busy);
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == spnt_pkg::ST_IDLE)
    else $error("frame end while search busy");
  a_mul_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spnt_pkg::ST_MUL |=> state_r == spnt_pkg::ST_FREQ)
    else $error("sequence broken");
  a_decide_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spnt_pkg::ST_DECIDE && sts.emit && sts.out_busy)
      |=> state_r == spnt_pkg::ST_DECIDE)
    else $error("result dropped");
endmodule
`default_nettype wire

// ----- rtl/spnt_dp.sv -----
// datapath: peak search, note quantizer and note tracker
`default_nettype none
module spnt_dp #(
  parameter int FRAME_BINS = 1024,
  parameter int BIN_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       bin_take,
  input  wire logic signed [BIN_BITS-1:0] bin_real,
  input  wire logic signed [BIN_BITS-1:0] bin_imag,
  input  wire logic                       last_bin,
  input  wire logic [23:0]                noise_floor,
  input  wire logic [15:0]                bin_width_hz,
  input  wire spnt_pkg::cmd_t             cmd,
  input  wire logic                       out_ready,
  output spnt_pkg::sts_t                  sts,
  output logic                            res_valid,
  output logic [6:0]                      res_note,
  output logic [15:0]                     res_count
);
  localparam int IdxW = (FRAME_BINS > 1) ? $clog2(FRAME_BINS) : 1;
  localparam int PowW = 2 * BIN_BITS + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BINS - 1);
  localparam int FW = spnt_pkg::FreqW;

  logic [PowW-1:0] peak_power_r;
  logic [IdxW-1:0] peak_index_r, bin_position_r;
  logic [BIN_BITS-1:0] mag_a, mag_b;
  logic [PowW-1:0] power;

  // magnitude of two's complement, most negative maps to 2^(n-1)
  assign mag_a = bin_real[BIN_BITS-1] ? BIN_BITS'(-bin_real) : bin_real;
  assign mag_b = bin_imag[BIN_BITS-1] ? BIN_BITS'(-bin_imag) : bin_imag;
  assign power = PowW'(mag_a * mag_a) + PowW'(mag_b * mag_b);

  logic [PowW-1:0] lat_power_r;
  logic [IdxW-1:0] lat_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_power_r <= '0;
      peak_index_r <= '0;
      bin_position_r <= '0;
    end else if (bin_take) begin
      if (bin_position_r == '0 || power > peak_power_r) begin
        peak_power_r <= power;
        peak_index_r <= bin_position_r;
      end
      if (last_bin) bin_position_r <= '0;
      else if (bin_position_r < LastIdx) bin_position_r <= bin_position_r + 1'b1;
    end
  end

  // latch the frame winner for the search
  always_ff @(posedge clk) begin
    if (bin_take && last_bin) begin
      if (bin_position_r == '0 || power > peak_power_r) begin
        lat_power_r <= power;
        lat_index_r <= bin_position_r;
      end else begin
        lat_power_r <= peak_power_r;
        lat_index_r <= peak_index_r;
      end
    end
  end

  logic [47:0] floor_sq_r;
  logic [IdxW+15:0] prod_r;
  logic loud_r;
  logic [FW-1:0] f1_r, f2_r, v_r;
  logic fzero_r;
  logic [2:0] oct_r;
  logic [6:0] n1_r, n_cur;
  logic [6:0] held_note_r;
  logic held_valid_r;
  logic [15:0] frame_count_r;
  logic res_valid_r;
  logic note_change;
  logic [FW-1:0] fsel;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      floor_sq_r <= noise_floor * noise_floor;
      prod_r <= lat_index_r * bin_width_hz;
    end
    if (cmd.freq) begin
      loud_r <= PowW'(lat_power_r) > PowW'(floor_sq_r);
      f1_r <= FW'({prod_r, 1'b0});
      f2_r <= FW'({prod_r, 1'b0}) + FW'(bin_width_hz);
    end
  end

  assign fsel = cmd.save1 ? f2_r : f1_r;
  logic load2_r;

  // fold: one doubling or halving per cycle, then octave steps
  always_ff @(posedge clk) begin
    if (!rst_n) load2_r <= 1'b0;
    else if (cmd.freq) load2_r <= 1'b0;
    else if (cmd.save1) load2_r <= 1'b1;
    if (cmd.load) begin
      v_r <= (load2_r ? f2_r : f1_r) << 16;
      fzero_r <= (load2_r ? f2_r : f1_r) == '0;
      oct_r <= '0;
    end else if (cmd.fold && !fzero_r) begin
      if (v_r <= spnt_pkg::FoldLow) v_r <= v_r << 1;
      else if (v_r >= spnt_pkg::FoldHigh) v_r <= v_r >> 1;
    end else if (cmd.oct && !fzero_r) begin
      if (oct_r < 3'd4 && v_r >= (spnt_pkg::FoldLow << (oct_r + 3'd1)))
        oct_r <= oct_r + 3'd1;
    end
  end

  assign sts.fold_done = fzero_r ||
    (v_r > spnt_pkg::FoldLow && v_r < spnt_pkg::FoldHigh);
  assign sts.oct_done = fzero_r || oct_r == 3'd4 ||
    v_r < (spnt_pkg::FoldLow << (oct_r + 3'd1));
  assign sts.emit = note_change;
  assign sts.out_busy = res_valid_r && !out_ready;
  assign res_valid = res_valid_r;

  logic [3:0] cnt;
  always_comb begin
    cnt = '0;
    for (int m = 0; m < 12; m++)
      if (v_r > (spnt_pkg::note_edge(4'(m)) << oct_r)) cnt = cnt + 4'd1;
    n_cur = fzero_r ? spnt_pkg::NoteRest :
      spnt_pkg::NoteBase + 7'(oct_r) * 7'd12 + 7'(cnt);
  end

  logic [6:0] n2_r, note;
  always_ff @(posedge clk) begin
    if (cmd.cnt) begin
      if (cmd.save1) n1_r <= n_cur;
      else n2_r <= n_cur;
    end
  end

  always_comb begin
    if (!loud_r) note = spnt_pkg::NoteRest;
    else if (n1_r == n2_r) note = n1_r;
    else if (held_valid_r && (n1_r == held_note_r || n2_r == held_note_r))
      note = held_note_r;
    else note = n2_r;
  end

  assign note_change = held_valid_r && (note != held_note_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      frame_count_r <= '0;
    end else if (cmd.decide) begin
      if (!held_valid_r) begin
        if (note != spnt_pkg::NoteRest) begin
          held_note_r <= note;
          held_valid_r <= 1'b1;
          frame_count_r <= 16'd1;
        end
      end else if (note != held_note_r) begin
        res_note <= held_note_r;
        res_count <= frame_count_r;
        held_note_r <= note;
        frame_count_r <= 16'd1;
      end else if (frame_count_r < spnt_pkg::CountMax) begin
        frame_count_r <= frame_count_r + 16'd1;
      end
    end
  end

  // output register: a new result may load in the cycle the old one leaves
  always_ff @(posedge clk) begin
    if (!rst_n) res_valid_r <= 1'b0;
    else if (cmd.decide && note_change) res_valid_r <= 1'b1;
    else if (out_ready) res_valid_r <= 1'b0;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bin_position_r <= LastIdx) else $error("bin position overran");
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> frame_count_r != '0) else $error("held count zero");
  a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
    oct_r <= 3'd4) else $error("octave out of range");
  a_fsel_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.freq |=> fsel == f1_r || fsel == f2_r) else $error("freq select");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_ready) |=> res_valid_r && $stable({res_note, res_count}))
    else $error("result changed while waiting");
endmodule
`default_nettype wire
